// ----- hdl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the message expiry tracker
// Entry layout, cell chain commands, result layout, codes and FSM states.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int ENTRIES = 32;                    // 2..63
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int EXP_W   = 63;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_TIME  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [63:0]      id;
    logic [EXP_W-1:0] expiry;
    logic [31:0]      handle;
    logic [15:0]      length;
  } cell_data_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ROT,      // circular shift toward the head over the live entries
    CMD_DEL,      // close the gap at pos
    CMD_REPL,     // close the gap at pos, write new entry at the tail
    CMD_APPEND,   // write new entry just past the tail
    CMD_UPD       // refresh handle and length at pos
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    cell_data_t       data;
    logic [63:0]      key_id;
    logic [EXP_W-1:0] key_exp;
    logic [63:0]      now;
  } chain_cmd_t;

  typedef struct packed {
    logic match;
    logic exp_eq;
    logic due;
  } cell_flags_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             expiry_item;
    cell_data_t       entry;
    logic             is_expired;
    logic [5:0]       live_count;
    logic [5:0]       expired_total;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_SCAN,
    S_PICK
  } state_t;

endpackage

// ----- hdl/met_if.sv -----
// ----------------------------------------------------------------------------
// met_if: item channels of the message expiry tracker
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface met_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] msg_id;
  logic [63:0] expire_time;
  logic [63:0] now;
  logic [31:0] data_handle;
  logic [15:0] data_length;

  modport source (output valid, action, msg_id, expire_time, now, data_handle,
                  data_length, input ready);
  modport sink (input valid, action, msg_id, expire_time, now, data_handle,
                data_length, output ready);
endinterface

interface met_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        expiry_item;
  logic [63:0] msg_id_out;
  logic [62:0] expire_time_out;
  logic [31:0] data_handle_out;
  logic [15:0] data_length_out;
  logic        is_expired;
  logic [5:0]  live_count;
  logic [5:0]  expired_total;
  logic        last;

  modport source (output valid, status, expiry_item, msg_id_out, expire_time_out,
                  data_handle_out, data_length_out, is_expired, live_count,
                  expired_total, last, input ready);
  modport sink (input valid, status, expiry_item, msg_id_out, expire_time_out,
                data_handle_out, data_length_out, is_expired, live_count,
                expired_total, last, output ready);
endinterface

// ----- hdl/message_expiry_tracker.sv -----
// ----------------------------------------------------------------------------
// message_expiry_tracker: timeout table with expiry-ordered release
// Entries live in a chain of cells in insertion order; lookups are parallel
// compares, expire scans the chain by rotating it through the head cell.
// ----------------------------------------------------------------------------
// Sequence: add, remove and query pass S_LOOK and S_EXEC; the result is
//   registered once the output can load. Expire releases one due entry per
//   full rotation of the cell chain; a last rotation with none gives the summary.
// Throughput: one item at a time; a new item is taken once the last result
//   of the previous one is in the output register.
// Reset: rst_n (sync, active low) empties the table and clears the output.
module message_expiry_tracker (
  input  logic      clk,
  input  logic      rst_n,
  met_in_if.sink    in_chan,
  met_out_if.source out_chan
);
  import met_pkg::*;

  state_t state_r, state_nxt;

  // latched item
  logic [1:0]  act_r;
  logic [63:0] id_r;
  logic [63:0] exp_r;
  logic [63:0] now_r;
  logic [31:0] hdl_r;
  logic [15:0] len_r;

  // table occupancy
  logic [CNT_W-1:0] count_r, count_nxt;

  // lookup results
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             eqx_r, eqx_nxt;
  logic             due_at_r, due_at_nxt;

  // expire scan
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             bf_r, bf_nxt;
  logic [IDX_W-1:0] best_pos_r, best_pos_nxt;
  cell_data_t       best_r, best_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] due_cnt_r, due_cnt_nxt;
  logic [CNT_W-1:0] emitted_r, emitted_nxt;
  logic [CNT_W-1:0] fin_r, fin_nxt;

  // output register
  logic    ov_r, ov_nxt;
  result_t res_r, res_nxt;
  logic    can_load;

  chain_cmd_t       cmd;
  cell_data_t       head;
  logic [ENTRIES-1:0] match_v, eq_v, due_v, live_v;
  logic             any_match;
  logic [IDX_W-1:0] first_pos;
  logic             take;

  met_chain u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .head_o   (head),
    .match_o  (match_v),
    .exp_eq_o (eq_v),
    .due_o    (due_v)
  );

  // only slots below the count hold live entries
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      live_v[i] = CNT_W'(i) < count_r;
    end
  end

  always_comb begin
    any_match = 1'b0;
    first_pos = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_v[i] && live_v[i]) begin
        any_match = 1'b1;
        first_pos = IDX_W'(i);
      end
    end
  end

  assign take          = in_chan.valid && in_chan.ready;
  assign in_chan.ready = state_r == S_IDLE;
  assign can_load      = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    eqx_nxt      = eqx_r;
    due_at_nxt   = due_at_r;
    k_nxt        = k_r;
    bf_nxt       = bf_r;
    best_pos_nxt = best_pos_r;
    best_nxt     = best_r;
    first_nxt    = first_r;
    due_cnt_nxt  = due_cnt_r;
    emitted_nxt  = emitted_r;
    fin_nxt      = fin_r;
    ov_nxt       = ov_r && !out_chan.ready;
    res_nxt      = res_r;

    cmd.op      = CMD_NOP;
    cmd.pos     = pos_r;
    cmd.count   = count_r;
    cmd.data    = '{id: id_r, expiry: exp_r[EXP_W-1:0], handle: hdl_r, length: len_r};
    cmd.key_id  = id_r;
    cmd.key_exp = exp_r[EXP_W-1:0];
    cmd.now     = now_r;

    unique case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_LOOK;
      end

      S_LOOK: begin
        found_nxt  = any_match;
        pos_nxt    = first_pos;
        eqx_nxt    = eq_v[first_pos];
        due_at_nxt = due_v[first_pos];
        k_nxt       = '0;
        bf_nxt      = 1'b0;
        first_nxt   = 1'b1;
        due_cnt_nxt = '0;
        emitted_nxt = '0;
        state_nxt   = (act_r == ACT_EXPIRE) ? S_SCAN : S_EXEC;
      end

      S_EXEC: begin
        if (can_load) begin
          res_nxt        = '0;
          res_nxt.status = ST_OK;
          res_nxt.last   = 1'b1;
          case (act_r)
            ACT_ADD: begin
              if (exp_r[63]) begin
                res_nxt.status = ST_BAD_TIME;
              end else if (found_r && eqx_r) begin
                cmd.op = CMD_UPD;
              end else if (found_r) begin
                // new expiry: entry moves to the tail as the latest insertion
                cmd.op = CMD_REPL;
              end else if (count_r == CNT_W'(ENTRIES)) begin
                res_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CMD_APPEND;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (found_r) begin
                cmd.op    = CMD_DEL;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            default: begin
              if (found_r) begin
                res_nxt.is_expired = due_at_r;
              end else begin
                res_nxt.status     = ST_NOT_FOUND;
                res_nxt.is_expired = 1'b1;
              end
            end
          endcase
          res_nxt.live_count = 6'(count_nxt);
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        if (k_r == count_r) begin
          state_nxt = S_PICK;
        end else begin
          // head holds original slot k; strict less keeps the earliest on ties
          cmd.op = CMD_ROT;
          k_nxt  = k_r + CNT_W'(1);
          if (due_v[0]) begin
            if (first_r) due_cnt_nxt = due_cnt_r + CNT_W'(1);
            if (!bf_r || head.expiry < best_r.expiry) begin
              bf_nxt       = 1'b1;
              best_nxt     = head;
              best_pos_nxt = k_r[IDX_W-1:0];
            end
          end
        end
      end

      S_PICK: begin
        if (can_load) begin
          res_nxt = '0;
          ov_nxt  = 1'b1;
          if (bf_r) begin
            fin_nxt             = first_r ? count_r - due_cnt_r : fin_r;
            res_nxt.expiry_item = 1'b1;
            res_nxt.entry       = best_r;
            res_nxt.live_count  = 6'(fin_nxt);
            cmd.op      = CMD_DEL;
            cmd.pos     = best_pos_r;
            count_nxt   = count_r - CNT_W'(1);
            emitted_nxt = emitted_r + CNT_W'(1);
            k_nxt       = '0;
            bf_nxt      = 1'b0;
            first_nxt   = 1'b0;
            state_nxt   = S_SCAN;
          end else begin
            res_nxt.live_count    = 6'(count_r);
            res_nxt.expired_total = 6'(emitted_r);
            res_nxt.last          = 1'b1;
            state_nxt             = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      act_r <= in_chan.action;
      id_r  <= in_chan.msg_id;
      exp_r <= in_chan.expire_time;
      now_r <= in_chan.now;
      hdl_r <= in_chan.data_handle;
      len_r <= in_chan.data_length;
    end
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    eqx_r      <= eqx_nxt;
    due_at_r   <= due_at_nxt;
    k_r        <= k_nxt;
    bf_r       <= bf_nxt;
    best_pos_r <= best_pos_nxt;
    best_r     <= best_nxt;
    first_r    <= first_nxt;
    due_cnt_r  <= due_cnt_nxt;
    emitted_r  <= emitted_nxt;
    fin_r      <= fin_nxt;
    res_r      <= res_nxt;
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.expiry_item     = res_r.expiry_item;
  assign out_chan.msg_id_out      = res_r.entry.id;
  assign out_chan.expire_time_out = res_r.entry.expiry;
  assign out_chan.data_handle_out = res_r.entry.handle;
  assign out_chan.data_length_out = res_r.entry.length;
  assign out_chan.is_expired      = res_r.is_expired;
  assign out_chan.live_count      = res_r.live_count;
  assign out_chan.expired_total   = res_r.expired_total;
  assign out_chan.last            = res_r.last;

endmodule

// ----- hdl/met_cell.sv -----
// ----------------------------------------------------------------------------
// met_cell: one table slot
// Holds one entry, compares it with the broadcast key and takes data from
// its right neighbor, the head or the command.
// ----------------------------------------------------------------------------
module met_cell (
  input  logic                      clk,
  input  logic [met_pkg::IDX_W-1:0] idx,
  input  met_pkg::chain_cmd_t       cmd,
  input  met_pkg::cell_data_t       right,
  input  met_pkg::cell_data_t       head,
  output met_pkg::cell_data_t       data_o,
  output met_pkg::cell_flags_t      flags_o
);
  import met_pkg::*;

  cell_data_t data_r;
  cell_data_t data_nxt;
  logic       is_last;
  logic       is_next;
  logic       at_pos;
  logic       past_pos;

  assign is_last  = (CNT_W'(idx) + CNT_W'(1)) == cmd.count;
  assign is_next  = CNT_W'(idx) == cmd.count;
  assign at_pos   = idx == cmd.pos;
  assign past_pos = idx >= cmd.pos;

  always_comb begin
    flags_o.match  = data_r.id == cmd.key_id;
    flags_o.exp_eq = data_r.expiry == cmd.key_exp;
    flags_o.due    = {1'b0, data_r.expiry} <= cmd.now;
  end

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CMD_ROT: begin
        data_nxt = is_last ? head : right;
      end
      CMD_DEL: begin
        if (past_pos) data_nxt = right;
      end
      CMD_REPL: begin
        if (is_last) data_nxt = cmd.data;
        else if (past_pos) data_nxt = right;
      end
      CMD_APPEND: begin
        if (is_next) data_nxt = cmd.data;
      end
      CMD_UPD: begin
        if (at_pos) begin
          data_nxt.handle = cmd.data.handle;
          data_nxt.length = cmd.data.length;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ----- hdl/met_chain.sv -----
// ----------------------------------------------------------------------------
// met_chain: row of table cells
// Slot 0 is the head; each cell hands its entry to its left neighbor.
// ----------------------------------------------------------------------------
module met_chain (
  input  logic                        clk,
  input  met_pkg::chain_cmd_t         cmd,
  output met_pkg::cell_data_t         head_o,
  output logic [met_pkg::ENTRIES-1:0] match_o,
  output logic [met_pkg::ENTRIES-1:0] exp_eq_o,
  output logic [met_pkg::ENTRIES-1:0] due_o
);
  import met_pkg::*;

  cell_data_t  slot_d [ENTRIES];
  cell_data_t  slot_r [ENTRIES];
  cell_flags_t slot_f [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_end
      assign slot_r[i] = '0;
    end else begin : g_mid
      assign slot_r[i] = slot_d[i+1];
    end

    met_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .cmd     (cmd),
      .right   (slot_r[i]),
      .head    (slot_d[0]),
      .data_o  (slot_d[i]),
      .flags_o (slot_f[i])
    );

    assign match_o[i]  = slot_f[i].match;
    assign exp_eq_o[i] = slot_f[i].exp_eq;
    assign due_o[i]    = slot_f[i].due;
  end

  assign head_o = slot_d[0];

endmodule
